>>> rtl/pcmdm_pkg.sv
package pcmdm_pkg;

    // WAV format tags that the block understands.
    localparam logic [15:0] FMT_PCM        = 16'h0001;
    localparam logic [15:0] FMT_FLOAT      = 16'h0003;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

    // Supported sample widths in bits.
    localparam logic [15:0] BITS_8  = 16'd8;
    localparam logic [15:0] BITS_16 = 16'd16;
    localparam logic [15:0] BITS_24 = 16'd24;
    localparam logic [15:0] BITS_32 = 16'd32;

    // Register reset values.
    localparam logic [15:0] RST_FORMAT_CODE   = FMT_PCM;
    localparam logic [15:0] RST_SAMPLE_BITS   = BITS_16;
    localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;

    // IEEE single exponent landmarks for the conversion to Q1.31.
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;  // infinity or NaN
    localparam logic [7:0] EXP_SAT     = 8'd127; // magnitude of 1.0 or more
    localparam logic [7:0] EXP_TOP     = 8'd126; // largest exponent that shifts in range
    localparam logic [7:0] EXP_MIN     = 8'd96;  // below this the result truncates to zero

    localparam logic [32:0] Q31_POS_SAT = 33'h0_7FFF_FFFF;
    localparam logic [32:0] Q31_NEG_MAG = 33'h0_8000_0000;

    // Register map: register i sits at byte address 4*i.
    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FORMAT_CODE   = 2'd0,
        REG_SAMPLE_BITS   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

endpackage

>>> rtl/pcm_sample_downmix_to_mono.sv
// PCM downmix to mono. Each input word is one channel sample of an interleaved
// frame, right-aligned in i_raw_sample. It is converted to signed Q1.31 according
// to the format registers (8-bit unsigned, 16/24/32-bit signed integer PCM, or
// 32-bit IEEE float truncated toward zero and saturated) and added to a running
// frame sum. The word that completes a frame produces one output word: the frame
// sum divided by the channel count, truncated toward zero, plus an error flag
// that is set when any sample of the frame had an unsupported format or width,
// or when the channel count is zero or larger than MAX_CHANNELS. An error frame
// always reports a sample of zero. Accumulation, negation and the divide steps
// run through one shared adder under a small sequencer, and the block takes one
// input word at a time. A word that does not end a frame passes through accept,
// convert and accumulate before the next word is taken. A word that ends a frame
// adds the restoring divide, one quotient bit per cycle on the shared adder over
// all SUM_W bits of the frame sum, with a magnitude step before it and the sign
// handling and the output load after it. A frame that ends with its error flag
// set skips the divide and the sign handling and goes to the output load. The
// output load waits only while the previous result is still unread. The
// finished word sits in an output register, so the next input word is taken
// while the previous result still waits downstream. Registers are written
// through the APB port and are expected to change only while the block is idle.
module pcm_sample_downmix_to_mono #(
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Input sample channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [31:0]                       i_raw_sample,

    // Output mono channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [31:0]                o_mono_sample,
    output logic                              o_format_error,

    // Configuration port.
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [pcmdm_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [31:0]                       i_pwdata,
    output logic [31:0]                       o_prdata,
    output logic                              o_pready
);

    // Channel counter width: it must hold MAX_CHANNELS itself.
    localparam int unsigned IDX_W = $clog2(MAX_CHANNELS + 1);
    // Frame sum width: one 32-bit sample plus growth over a full frame, plus sign.
    localparam int unsigned SUM_W = 33 + $clog2(MAX_CHANNELS);
    localparam int unsigned CNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ACC,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_DONE
    } t_state;

    // Configuration registers.
    logic [15:0]      r_format_code;
    logic [15:0]      r_sample_bits;
    logic [3:0]       r_channel_count;

    // Sequencer and datapath registers.
    t_state           r_state, n_state;
    logic [31:0]      r_raw, n_raw;
    logic [32:0]      r_opnd, n_opnd;   // converted sample or its magnitude
    logic             r_opsub, n_opsub; // subtract r_opnd instead of adding it
    logic             r_cerr, n_cerr;   // conversion error of the current word
    logic [IDX_W-1:0] r_chan_idx, n_chan_idx;
    logic [SUM_W-1:0] r_sum, n_sum;     // frame sum, then divide shift register
    logic             r_frame_err, n_frame_err;
    logic             r_neg, n_neg;
    logic [IDX_W-1:0] r_div, n_div;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_mono, n_mono;
    logic             r_out_err, n_out_err;

    // The one shared adder: a + b + carry-in.
    logic [SUM_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_cin;

    assign alu_y = alu_a + alu_b + SUM_W'(alu_cin);

    // Frame length from the channel count, with the two error cases.
    logic             w_len_err;
    logic [IDX_W-1:0] w_len;

    always_comb begin
        if (r_channel_count == 4'd0) begin
            w_len_err = 1'b1;
            w_len     = IDX_W'(1);
        end else if (int'(r_channel_count) > int'(MAX_CHANNELS)) begin
            w_len_err = 1'b1;
            w_len     = IDX_W'(MAX_CHANNELS);
        end else begin
            w_len_err = 1'b0;
            w_len     = IDX_W'(r_channel_count);
        end
    end

    // Sample conversion, with one right shifter for the float path.
    logic        w_f_neg;
    logic [7:0]  w_f_exp;
    logic [23:0] w_f_man;
    logic [4:0]  w_f_shamt;
    logic [30:0] w_f_mag;
    logic [32:0] w_cv_opnd;
    logic        w_cv_sub;
    logic        w_cv_err;
    logic        w_is_int;

    assign w_f_neg   = r_raw[31];
    assign w_f_exp   = r_raw[30:23];
    assign w_f_man   = {1'b1, r_raw[22:0]};
    assign w_f_shamt = 5'(pcmdm_pkg::EXP_TOP - w_f_exp);
    assign w_f_mag   = {w_f_man, 7'b0} >> w_f_shamt;
    assign w_is_int  = (r_format_code == pcmdm_pkg::FMT_PCM)
                    || (r_format_code == pcmdm_pkg::FMT_EXTENSIBLE);

    always_comb begin
        w_cv_opnd = '0;
        w_cv_sub  = 1'b0;
        w_cv_err  = 1'b0;
        if ((r_format_code == pcmdm_pkg::FMT_FLOAT) && (r_sample_bits == pcmdm_pkg::BITS_32)) begin
            priority if (w_f_exp == pcmdm_pkg::EXP_SPECIAL && r_raw[22:0] != 23'd0) begin
                w_cv_opnd = '0; // NaN reads as zero
            end else if (w_f_exp >= pcmdm_pkg::EXP_SAT) begin
                // Infinity or a magnitude of at least 1.0 saturates.
                w_cv_opnd = w_f_neg ? pcmdm_pkg::Q31_NEG_MAG : pcmdm_pkg::Q31_POS_SAT;
                w_cv_sub  = w_f_neg;
            end else if (w_f_exp >= pcmdm_pkg::EXP_MIN) begin
                w_cv_opnd = 33'(w_f_mag);
                w_cv_sub  = w_f_neg;
            end else begin
                w_cv_opnd = '0; // too small, or zero and denormals
            end
        end else if (w_is_int && r_sample_bits == pcmdm_pkg::BITS_8) begin
            w_cv_opnd = {~r_raw[7], ~r_raw[7], r_raw[6:0], 24'b0};
        end else if (w_is_int && r_sample_bits == pcmdm_pkg::BITS_16) begin
            w_cv_opnd = {r_raw[15], r_raw[15:0], 16'b0};
        end else if (w_is_int && r_sample_bits == pcmdm_pkg::BITS_24) begin
            w_cv_opnd = {r_raw[23], r_raw[23:0], 8'b0};
        end else if (w_is_int && r_sample_bits == pcmdm_pkg::BITS_32) begin
            w_cv_opnd = {r_raw[31], r_raw};
        end else begin
            w_cv_err = 1'b1;
        end
    end

    // Divide step helpers: the partial remainder with the next dividend bit.
    logic [IDX_W:0]   w_shifted;
    logic             w_acc_end;
    logic [IDX_W:0]   w_idx_inc;

    assign w_shifted = {r_rem, r_sum[SUM_W-1]};
    assign w_idx_inc = {1'b0, r_chan_idx} + (IDX_W+1)'(1);
    assign w_acc_end = w_idx_inc >= {1'b0, w_len};

    assign o_ready = (r_state == S_IDLE);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_raw       = r_raw;
        n_opnd      = r_opnd;
        n_opsub     = r_opsub;
        n_cerr      = r_cerr;
        n_chan_idx  = r_chan_idx;
        n_sum       = r_sum;
        n_frame_err = r_frame_err;
        n_neg       = r_neg;
        n_div       = r_div;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_mono      = r_mono;
        n_out_err   = r_out_err;
        alu_a       = '0;
        alu_b       = '0;
        alu_cin     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_raw   = i_raw_sample;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_opnd  = w_cv_opnd;
                n_opsub = w_cv_sub;
                n_cerr  = w_cv_err;
                n_state = S_ACC;
            end
            S_ACC: begin
                // Add or subtract the converted sample into the frame sum.
                alu_a   = r_sum;
                alu_b   = r_opsub ? ~SUM_W'(signed'(r_opnd)) : SUM_W'(signed'(r_opnd));
                alu_cin = r_opsub;
                n_sum   = alu_y;
                n_frame_err = r_frame_err || r_cerr || w_len_err;
                if (w_acc_end) begin
                    n_div  = w_len;
                    n_neg  = alu_y[SUM_W-1];
                    n_rem  = '0;
                    n_step = '0;
                    if (n_frame_err) begin
                        n_sum   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ABS;
                    end
                end else begin
                    n_chan_idx = IDX_W'(w_idx_inc);
                    n_state    = S_IDLE;
                end
            end
            S_ABS: begin
                alu_b   = ~r_sum;
                alu_cin = 1'b1;
                if (r_neg) begin
                    n_sum = alu_y;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                // One restoring divide step: try to subtract the divisor.
                alu_a   = SUM_W'(w_shifted);
                alu_b   = ~SUM_W'(r_div);
                alu_cin = 1'b1;
                if (alu_y[SUM_W-1]) begin
                    n_rem = IDX_W'(w_shifted);
                    n_sum = {r_sum[SUM_W-2:0], 1'b0};
                end else begin
                    n_rem = IDX_W'(alu_y);
                    n_sum = {r_sum[SUM_W-2:0], 1'b1};
                end
                n_step = r_step + CNT_W'(1);
                if (r_step == CNT_W'(SUM_W - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                alu_b   = ~r_sum;
                alu_cin = 1'b1;
                if (r_neg) begin
                    n_sum = alu_y;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait here only while the previous word is still unread.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_mono      = r_sum[31:0];
                    n_out_err   = r_frame_err;
                    n_sum       = '0;
                    n_frame_err = 1'b0;
                    n_chan_idx  = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan_idx  <= '0;
            r_sum       <= '0;
            r_frame_err <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan_idx  <= n_chan_idx;
            r_sum       <= n_sum;
            r_frame_err <= n_frame_err;
            r_out_valid <= n_out_valid;
        end
        r_raw     <= n_raw;
        r_opnd    <= n_opnd;
        r_opsub   <= n_opsub;
        r_cerr    <= n_cerr;
        r_neg     <= n_neg;
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_mono    <= n_mono;
        r_out_err <= n_out_err;
    end

    assign o_valid        = r_out_valid;
    assign o_mono_sample  = signed'(r_mono);
    assign o_format_error = r_out_err;

    // Configuration registers, written in the APB access phase.
    pcmdm_pkg::t_reg_idx w_reg_idx;
    logic                w_cfg_wr;

    assign w_reg_idx = pcmdm_pkg::t_reg_idx'(i_paddr[3:2]);
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite;
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_code   <= pcmdm_pkg::RST_FORMAT_CODE;
            r_sample_bits   <= pcmdm_pkg::RST_SAMPLE_BITS;
            r_channel_count <= pcmdm_pkg::RST_CHANNEL_COUNT;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                pcmdm_pkg::REG_FORMAT_CODE:   r_format_code   <= i_pwdata[15:0];
                pcmdm_pkg::REG_SAMPLE_BITS:   r_sample_bits   <= i_pwdata[15:0];
                pcmdm_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            pcmdm_pkg::REG_FORMAT_CODE:   o_prdata = {16'b0, r_format_code};
            pcmdm_pkg::REG_SAMPLE_BITS:   o_prdata = {16'b0, r_sample_bits};
            pcmdm_pkg::REG_CHANNEL_COUNT: o_prdata = {28'b0, r_channel_count};
            default:                      o_prdata = '0;
        endcase
    end

    // The channel position never reaches MAX_CHANNELS between words.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan_idx < IDX_W'(MAX_CHANNELS))
        else $error("channel index out of range");

    // An error frame always reports a zero sample.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_mono == 32'd0))
        else $error("error frame with nonzero sample");

    // The partial remainder stays below the divisor throughout the divide.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divide remainder out of range");

    // An accepted word always moves on to conversion in the next cycle.
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CONV))
        else $error("accepted word not converted");

endmodule
